// ===== hdl/ssi_pkg.sv =====
// Shared widths, sideband type and arithmetic helpers for the segment-sphere test.
`timescale 1ns / 1ps
package ssi_pkg;

    localparam int AXES       = 3;
    localparam int COORD_W    = 32;
    localparam int RADIUS_W   = 31;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = DIFF_W;
    localparam int HALF_W     = MAG_W;
    localparam int SQ_W       = 2 * HALF_W;
    localparam int RR_W       = 2 * RADIUS_W;
    localparam int PROD_W     = 2 * SQ_W;
    localparam int ROOT_W     = PROD_W / 2;
    localparam int REM_W      = ROOT_W + 4;
    localparam int NUM_W      = SQ_W + MAG_W + 1;
    localparam int DEN_W      = SQ_W + 1;
    localparam int QUO_W      = MAG_W;
    localparam int IN_DATA_W  = 320;
    localparam int OUT_DATA_W = AXES * COORD_W;

    // Values that travel alongside the wide arithmetic.
    typedef struct packed {
        logic                            hit;
        logic                            start_in;
        logic [AXES-1:0][COORD_W-1:0]    start;
        logic [AXES-1:0]                 dneg;
        logic [AXES-1:0][MAG_W-1:0]      dmag;
        logic [SQ_W-1:0]                 a;
        logic [SQ_W-1:0]                 b;
    } ssi_side_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [SQ_W-1:0] umul_half(input logic [HALF_W-1:0] x,
                                                  input logic [HALF_W-1:0] y);
        logic [SQ_W-1:0] xe;
        logic [SQ_W-1:0] ye;
        xe = {{HALF_W{1'b0}}, x};
        ye = {{HALF_W{1'b0}}, y};
        return xe * ye;
    endfunction

endpackage

// ===== hdl/ssi_front.sv =====
// Front stages: differences, dot products, start test and discriminant.
`timescale 1ns / 1ps
module ssi_front import ssi_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [AXES-1:0][COORD_W-1:0] start_pt,
    input  logic [AXES-1:0][COORD_W-1:0] end_pt,
    input  logic [AXES-1:0][COORD_W-1:0] center,
    input  logic [RADIUS_W-1:0]          radius,
    output logic                         out_valid,
    output ssi_side_t                    out_side,
    output logic [PROD_W-1:0]            out_disc
);

    logic [6:0] valid_reg;

    // Stage 1: offsets from the start.
    logic [AXES-1:0][COORD_W-1:0] s1_start_reg;
    logic [AXES-1:0][DIFF_W-1:0]  s1_d_reg, s1_w_reg, s1_d_next, s1_w_next;
    logic [RADIUS_W-1:0]          s1_r_reg;

    // Stage 2: per-axis products.
    ssi_side_t                  s2_side_reg, s2_side_next;
    logic [AXES-1:0][SQ_W-1:0]  s2_ww_reg, s2_aa_reg, s2_wd_reg;
    logic [AXES-1:0][SQ_W-1:0]  s2_ww_next, s2_aa_next, s2_wd_next;
    logic [AXES-1:0]            s2_neg_reg, s2_neg_next;
    logic [RR_W-1:0]            s2_rr_reg, s2_rr_next;

    // Stage 3: sums.
    ssi_side_t       s3_side_reg, s3_side_next;
    logic [SQ_W-1:0] s3_ww_reg, s3_bpos_reg, s3_bneg_reg;
    logic [SQ_W-1:0] s3_ww_next, s3_bpos_next, s3_bneg_next;
    logic [RR_W-1:0] s3_rr_reg;

    // Stage 4: start test, signed projection and c.
    ssi_side_t       s4_side_reg, s4_side_next;
    logic [SQ_W-1:0] s4_c_reg, s4_c_next;
    logic            s4_azero_reg, s4_back_reg;

    // Stage 5: partial products of b*b and a*c.
    ssi_side_t       s5_side_reg, s5_side_next;
    logic [SQ_W-1:0] s5_bhh_reg, s5_bhl_reg, s5_bll_reg;
    logic [SQ_W-1:0] s5_ahh_reg, s5_ahl_reg, s5_alh_reg, s5_all_reg;
    logic            s5_miss_reg;

    // Stage 6: full products.
    ssi_side_t         s6_side_reg;
    logic [PROD_W-1:0] s6_bb_reg, s6_ac_reg, s6_bb_next, s6_ac_next;
    logic              s6_miss_reg;

    // Stage 7: discriminant and hit decision.
    ssi_side_t         s7_side_reg, s7_side_next;
    logic [PROD_W-1:0] s7_disc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            s1_d_next[k] = {end_pt[k][COORD_W-1], end_pt[k]}
                         - {start_pt[k][COORD_W-1], start_pt[k]};
            s1_w_next[k] = {center[k][COORD_W-1], center[k]}
                         - {start_pt[k][COORD_W-1], start_pt[k]};
        end
    end

    always_comb begin
        logic [MAG_W-1:0] wm;
        logic [MAG_W-1:0] dm;
        logic [RR_W-1:0]  re;
        s2_side_next = '0;
        s2_side_next.start = s1_start_reg;
        for (int k = 0; k < AXES; k++) begin
            wm = mag_of(s1_w_reg[k]);
            dm = mag_of(s1_d_reg[k]);
            s2_side_next.dmag[k] = dm;
            s2_side_next.dneg[k] = s1_d_reg[k][DIFF_W-1];
            s2_ww_next[k]  = umul_half(wm, wm);
            s2_aa_next[k]  = umul_half(dm, dm);
            s2_wd_next[k]  = umul_half(wm, dm);
            s2_neg_next[k] = s1_w_reg[k][DIFF_W-1] ^ s1_d_reg[k][DIFF_W-1];
        end
        re = RR_W'(s1_r_reg);
        s2_rr_next = re * re;
    end

    always_comb begin
        s3_side_next   = s2_side_reg;
        s3_side_next.a = s2_aa_reg[0] + s2_aa_reg[1] + s2_aa_reg[2];
        s3_ww_next     = s2_ww_reg[0] + s2_ww_reg[1] + s2_ww_reg[2];
        s3_bpos_next   = '0;
        s3_bneg_next   = '0;
        for (int k = 0; k < AXES; k++) begin
            if (s2_neg_reg[k]) begin
                s3_bneg_next = s3_bneg_next + s2_wd_reg[k];
            end else begin
                s3_bpos_next = s3_bpos_next + s2_wd_reg[k];
            end
        end
    end

    always_comb begin
        s4_side_next          = s3_side_reg;
        s4_side_next.start_in = (s3_ww_reg <= SQ_W'(s3_rr_reg));
        s4_side_next.b        = s3_bpos_reg - s3_bneg_reg;
        s4_c_next             = s3_ww_reg - SQ_W'(s3_rr_reg);
    end

    assign s5_side_next = s4_side_reg;

    always_comb begin
        s6_bb_next = {s5_bhh_reg, {SQ_W{1'b0}}}
                   + PROD_W'({s5_bhl_reg, {(HALF_W + 1){1'b0}}})
                   + PROD_W'(s5_bll_reg);
        s6_ac_next = {s5_ahh_reg, {SQ_W{1'b0}}}
                   + PROD_W'({s5_ahl_reg, {HALF_W{1'b0}}})
                   + PROD_W'({s5_alh_reg, {HALF_W{1'b0}}})
                   + PROD_W'(s5_all_reg);
    end

    always_comb begin
        s7_side_next     = s6_side_reg;
        s7_side_next.hit = s6_side_reg.start_in
                         | (!s6_miss_reg && (s6_ac_reg <= s6_bb_reg));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_start_reg <= start_pt;
            s1_d_reg     <= s1_d_next;
            s1_w_reg     <= s1_w_next;
            s1_r_reg     <= radius;

            s2_side_reg  <= s2_side_next;
            s2_ww_reg    <= s2_ww_next;
            s2_aa_reg    <= s2_aa_next;
            s2_wd_reg    <= s2_wd_next;
            s2_neg_reg   <= s2_neg_next;
            s2_rr_reg    <= s2_rr_next;

            s3_side_reg  <= s3_side_next;
            s3_ww_reg    <= s3_ww_next;
            s3_bpos_reg  <= s3_bpos_next;
            s3_bneg_reg  <= s3_bneg_next;
            s3_rr_reg    <= s2_rr_reg;

            s4_side_reg  <= s4_side_next;
            s4_c_reg     <= s4_c_next;
            s4_azero_reg <= (s3_side_reg.a == '0);
            s4_back_reg  <= (s3_bneg_reg > s3_bpos_reg);

            s5_side_reg  <= s5_side_next;
            s5_miss_reg  <= s4_azero_reg | s4_back_reg | (s4_side_reg.b >= s4_side_reg.a);
            s5_bhh_reg   <= umul_half(s4_side_reg.b[SQ_W-1:HALF_W], s4_side_reg.b[SQ_W-1:HALF_W]);
            s5_bhl_reg   <= umul_half(s4_side_reg.b[SQ_W-1:HALF_W], s4_side_reg.b[HALF_W-1:0]);
            s5_bll_reg   <= umul_half(s4_side_reg.b[HALF_W-1:0], s4_side_reg.b[HALF_W-1:0]);
            s5_ahh_reg   <= umul_half(s4_side_reg.a[SQ_W-1:HALF_W], s4_c_reg[SQ_W-1:HALF_W]);
            s5_ahl_reg   <= umul_half(s4_side_reg.a[SQ_W-1:HALF_W], s4_c_reg[HALF_W-1:0]);
            s5_alh_reg   <= umul_half(s4_side_reg.a[HALF_W-1:0], s4_c_reg[SQ_W-1:HALF_W]);
            s5_all_reg   <= umul_half(s4_side_reg.a[HALF_W-1:0], s4_c_reg[HALF_W-1:0]);

            s6_side_reg  <= s5_side_reg;
            s6_bb_reg    <= s6_bb_next;
            s6_ac_reg    <= s6_ac_next;
            s6_miss_reg  <= s5_miss_reg;

            s7_side_reg  <= s7_side_next;
            s7_disc_reg  <= s6_bb_reg - s6_ac_reg;
        end
    end

    assign out_valid = valid_reg[6];
    assign out_side  = s7_side_reg;
    assign out_disc  = s7_disc_reg;

endmodule

// ===== hdl/ssi_sqrt.sv =====
// Integer square root of the discriminant, one root bit per pipeline stage.
`timescale 1ns / 1ps
module ssi_sqrt import ssi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  ssi_side_t         in_side,
    input  logic [PROD_W-1:0] in_disc,
    output logic              out_valid,
    output ssi_side_t         out_side,
    output logic [ROOT_W-1:0] out_root
);

    logic              vld_reg  [ROOT_W];
    ssi_side_t         side_reg [ROOT_W];
    logic [PROD_W-1:0] rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              v_in;
        ssi_side_t         side_in;
        logic [PROD_W-1:0] rad_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rad_in  = in_disc;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = vld_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down the next pair of radicand bits and try root*4+1.
        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[PROD_W-1:PROD_W-2]};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[k] <= side_in;
                rad_reg[k]  <= {rad_in[PROD_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// ===== hdl/ssi_div.sv =====
// Restoring divider for the three axes, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module ssi_div import ssi_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       ce,
    input  logic                       in_valid,
    input  ssi_side_t                  in_side,
    input  logic [AXES-1:0][NUM_W-1:0] in_num,
    output logic                       out_valid,
    output ssi_side_t                  out_side,
    output logic [AXES-1:0][QUO_W-1:0] out_quo
);

    logic                       vld_reg  [QUO_W];
    ssi_side_t                  side_reg [QUO_W];
    logic [AXES-1:0][DEN_W-1:0] rem_reg  [QUO_W];
    logic [AXES-1:0][QUO_W-1:0] low_reg  [QUO_W];
    logic [AXES-1:0][QUO_W-1:0] quo_reg  [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic                       v_in;
        ssi_side_t                  side_in;
        logic [AXES-1:0][DEN_W-1:0] rem_in, rem_next;
        logic [AXES-1:0][QUO_W-1:0] low_in, low_next, quo_in, quo_next;
        logic [DEN_W-1:0]           den;

        // The quotient fits QUO_W bits, so the upper numerator bits start below the divisor.
        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            for (genvar ax = 0; ax < AXES; ax++) begin : g_ax
                assign rem_in[ax] = in_num[ax][NUM_W-1:QUO_W];
                assign low_in[ax] = in_num[ax][QUO_W-1:0];
            end
            assign quo_in = '0;
        end else begin : g_next
            assign v_in    = vld_reg[j-1];
            assign side_in = side_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign low_in  = low_reg[j-1];
            assign quo_in  = quo_reg[j-1];
        end

        assign den = {side_in.a, 1'b0};

        always_comb begin
            logic [DEN_W:0] rem2;
            logic [DEN_W:0] diff;
            for (int ax = 0; ax < AXES; ax++) begin
                rem2 = {rem_in[ax], low_in[ax][QUO_W-1]};
                diff = rem2 - {1'b0, den};
                if (rem2 >= {1'b0, den}) begin
                    rem_next[ax] = diff[DEN_W-1:0];
                    quo_next[ax] = {quo_in[ax][QUO_W-2:0], 1'b1};
                end else begin
                    rem_next[ax] = rem2[DEN_W-1:0];
                    quo_next[ax] = {quo_in[ax][QUO_W-2:0], 1'b0};
                end
                low_next[ax] = {low_in[ax][QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (ce) begin
                vld_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[j] <= side_in;
                rem_reg[j]  <= rem_next;
                low_reg[j]  <= low_next;
                quo_reg[j]  <= quo_next;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];

endmodule

// ===== hdl/segment_sphere_intersect.sv =====
// Top level of the segment-sphere intersection pipeline.
//
// One request on the s_ channel carries a segment start, a segment end, a
// sphere centre in signed Q16.16 and a radius in unsigned Q15.16. For each request exactly one
// result leaves on the m_ channel: m_tuser is set when the segment meets the
// sphere, and m_tdata then holds the first entry point (or the start point
// when the start already lies inside the sphere); otherwise m_tdata is zero.
// The datapath is one pipeline of 110 register stages: seven set up the dot
// products and the discriminant, 66 take the square root one bit at a time,
// three scale the entry distance and 33 divide it, one bit at a time, and
// the last is the output register. A new request is taken in every cycle
// in which s_tready is high.
// Results come out in request order. When m_tready is low while a result is
// held, the whole pipeline holds and s_tready drops until it is taken.
// Reset (aresetn low at a clock edge) empties the pipeline; no result
// in flight survives it.
`timescale 1ns / 1ps
module segment_sphere_intersect import ssi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, center_x, center_y,
    // center_z (32 bits each), radius (31 bits), one pad bit.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit_x, hit_y, hit_z (32 bits each).
    output logic [OUT_DATA_W-1:0] m_tdata,
    // hit.
    output logic                  m_tuser
);

    logic                         ce;
    logic [AXES-1:0][COORD_W-1:0] start_pt, end_pt, center;
    logic [RADIUS_W-1:0]          radius;

    logic              fr_valid;
    ssi_side_t         fr_side;
    logic [PROD_W-1:0] fr_disc;

    logic              sq_valid;
    ssi_side_t         sq_side;
    logic [ROOT_W-1:0] sq_root;

    logic            n_valid_reg;
    ssi_side_t       n_side_reg;
    logic [SQ_W-1:0] n_reg;

    logic                      p_valid_reg;
    ssi_side_t                 p_side_reg;
    logic [AXES-1:0][SQ_W-1:0] p_hi_reg, p_lo_reg;

    logic                       q_valid_reg;
    ssi_side_t                  q_side_reg;
    logic [AXES-1:0][NUM_W-1:0] num_reg, num_next;

    logic                       dv_valid;
    ssi_side_t                  dv_side;
    logic [AXES-1:0][QUO_W-1:0] dv_quo;

    logic                         m_tvalid_reg;
    logic                         m_tuser_reg;
    logic [AXES-1:0][COORD_W-1:0] m_point_reg, m_point_next;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            start_pt[k] = s_tdata[k * COORD_W +: COORD_W];
            end_pt[k]   = s_tdata[(AXES + k) * COORD_W +: COORD_W];
            center[k]   = s_tdata[(2 * AXES + k) * COORD_W +: COORD_W];
        end
        radius = s_tdata[3 * AXES * COORD_W +: RADIUS_W];
    end

    ssi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .start_pt  (start_pt),
        .end_pt    (end_pt),
        .center    (center),
        .radius    (radius),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_disc  (fr_disc)
    );

    ssi_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_disc   (fr_disc),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // Entry distance along the segment, then |d| * n split in two halves of n.
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            num_next[k] = {p_hi_reg[k], {(HALF_W + 1){1'b0}}}
                        + NUM_W'({p_lo_reg[k], 1'b0})
                        + NUM_W'(p_side_reg.a);
        end
    end

    ssi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (q_valid_reg),
        .in_side   (q_side_reg),
        .in_num    (num_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            if (!dv_side.hit) begin
                m_point_next[k] = '0;
            end else if (dv_side.start_in) begin
                m_point_next[k] = dv_side.start[k];
            end else if (dv_side.dneg[k]) begin
                m_point_next[k] = dv_side.start[k] - dv_quo[k][COORD_W-1:0];
            end else begin
                m_point_next[k] = dv_side.start[k] + dv_quo[k][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
            q_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            n_valid_reg  <= sq_valid;
            p_valid_reg  <= n_valid_reg;
            q_valid_reg  <= p_valid_reg;
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            n_side_reg <= sq_side;
            n_reg      <= sq_side.b - sq_root;
            p_side_reg <= n_side_reg;
            for (int k = 0; k < AXES; k++) begin
                p_hi_reg[k] <= umul_half(n_side_reg.dmag[k], n_reg[SQ_W-1:HALF_W]);
                p_lo_reg[k] <= umul_half(n_side_reg.dmag[k], n_reg[HALF_W-1:0]);
            end
            q_side_reg  <= p_side_reg;
            num_reg     <= num_next;
            m_tuser_reg <= dv_side.hit;
            m_point_reg <= m_point_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_point_reg;

endmodule
